@@ rtl/clsr_pkg.sv @@
// Shared constants, command/status types and modular fold function for the shuffled LCG.
package clsr_pkg;

   localparam int DATA_W             = 31;
   localparam int MUL_W              = 16;
   localparam int PROD_W             = DATA_W + MUL_W;
   localparam int TABLE_SIZE_DEFAULT = 32;

   // request command codes
   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_SEED = 1'b1;

   localparam logic [31:0]       MOD_A        = 32'd2147483563;
   localparam logic [31:0]       MOD_B        = 32'd2147483399;
   localparam logic [MUL_W-1:0]  MUL_A        = 16'd40014;
   localparam logic [MUL_W-1:0]  MUL_B        = 16'd40692;
   // 2^31 is congruent to these values modulo MOD_A and MOD_B
   localparam logic [7:0]        FOLD_A       = 8'd85;
   localparam logic [7:0]        FOLD_B       = 8'd249;
   localparam logic [31:0]       WRAP_ADD     = 32'd2147483562;
   localparam logic [DATA_W-1:0] FIRST_RESET  = 31'd1;
   localparam logic [DATA_W-1:0] SECOND_RESET = 31'd123456789;

   typedef struct packed {
      logic load_seed;
      logic mult;
      logic step_a;
      logic step_b;
      logic fill;
      logic finish;
   } clsr_cmd_type;

   typedef struct packed {
      logic fill_done;
      logic out_free;
   } clsr_status_type;

   // Product of a 31-bit value and a 16-bit multiplier reduced modulo m.
   // High part folds back through f, one subtract finishes the job.
   function automatic logic [DATA_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
                                                  input logic [31:0]       m,
                                                  input logic [7:0]        f);
      logic [31:0] s;
      s = 32'(p[DATA_W-1:0]) + 32'(p[PROD_W-1:DATA_W]) * 32'(f);
      if (s >= m) begin
         s = s - m;
      end
      return s[DATA_W-1:0];
   endfunction

endpackage

@@ rtl/clsr_channels.sv @@
// Valid/ready channel interfaces for request and response words.
interface clsr_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [clsr_pkg::DATA_W-1:0] seed_value;

   modport source  (output valid, output command, output seed_value, input ready);
   modport sink    (input valid, input command, input seed_value, output ready);
   modport monitor (input valid, input command, input seed_value, input ready);
endinterface

interface clsr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [clsr_pkg::DATA_W-1:0] sample;

   modport source  (output valid, output sample, input ready);
   modport sink    (input valid, input sample, output ready);
   modport monitor (input valid, input sample, input ready);
endinterface

@@ rtl/clsr_datapath.sv @@
// Generator registers, modular multipliers, index unit and shuffle table memory.
module clsr_datapath #(
   parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  clsr_pkg::clsr_cmd_type      cmd,
   output clsr_pkg::clsr_status_type   status,
   input  logic [clsr_pkg::DATA_W-1:0] seed_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [clsr_pkg::DATA_W-1:0] rsp_sample
);
   import clsr_pkg::*;

   localparam int      IW     = $clog2(TABLE_SIZE);
   localparam int      CW     = $clog2(TABLE_SIZE + 8);
   localparam longint  BUCKET = 64'd1 + (64'd2147483563 - 64'd1) / TABLE_SIZE;
   localparam longint  RECIP  = (64'd1 << 31) / BUCKET;
   localparam int      MW     = $clog2(RECIP + 1);
   localparam int      QPW    = DATA_W + MW;

   logic [DATA_W-1:0] gen_a_ff, gen_a_in;
   logic [DATA_W-1:0] gen_b_ff, gen_b_in;
   logic [DATA_W-1:0] last_ff, last_in;
   logic [PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic [MW-1:0]     qest_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [IW-1:0]     idx_ff;
   logic [DATA_W-1:0] rd_ff;
   logic              rdv_ff;
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [DATA_W-1:0] mem [TABLE_SIZE];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] sample_ff;

   logic [DATA_W-1:0] red_a, red_b, seed_eff, picked, y_val;
   logic [QPW-1:0]    qprod;
   logic [31:0]       qb, rem, y_wide;
   logic [MW:0]       q_fix;
   logic [IW-1:0]     idx_next, wr_addr;
   logic              fill_wr, wr_en;
   logic [DATA_W-1:0] wr_data;

   assign red_a    = mod_fold(prod_a_ff, MOD_A, FOLD_A);
   assign red_b    = mod_fold(prod_b_ff, MOD_B, FOLD_B);
   assign seed_eff = (seed_value == '0) ? DATA_W'(1) : seed_value;

   // index = last / BUCKET: reciprocal estimate may be one short, then corrected
   assign qprod    = QPW'(last_ff) * QPW'(RECIP);
   assign qb       = 32'(qest_ff) * 32'(BUCKET);
   assign rem      = 32'(last_ff) - qb;
   assign q_fix    = (MW+1)'(qest_ff) + (MW+1)'(rem >= 32'(BUCKET));
   assign idx_next = (q_fix >= (MW+1)'(TABLE_SIZE)) ? IW'(TABLE_SIZE - 1) : IW'(q_fix);

   assign picked = rdv_ff ? rd_ff : '0;
   assign y_wide = (picked > gen_b_ff) ? (32'(picked) - 32'(gen_b_ff))
                                       : (32'(picked) + WRAP_ADD - 32'(gen_b_ff));
   assign y_val  = y_wide[DATA_W-1:0];

   assign fill_wr = cmd.fill && (cnt_ff < CW'(TABLE_SIZE));
   assign wr_en   = fill_wr || cmd.finish;
   assign wr_addr = cmd.finish ? idx_ff : IW'(cnt_ff);
   assign wr_data = cmd.finish ? gen_a_ff : red_a;

   always_comb begin
      gen_a_in     = gen_a_ff;
      gen_b_in     = gen_b_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_seed) begin
         gen_a_in = seed_eff;
         gen_b_in = seed_eff;
         cnt_in   = CW'(TABLE_SIZE + 7);
      end
      if (cmd.step_a) begin
         gen_a_in = red_a;
      end
      if (cmd.step_b) begin
         gen_b_in = red_b;
      end
      if (cmd.fill) begin
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            last_in = red_a;
         end
      end
      if (cmd.finish) begin
         last_in      = y_val;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_a_ff     <= FIRST_RESET;
         gen_b_ff     <= SECOND_RESET;
         last_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         gen_a_ff     <= gen_a_in;
         gen_b_ff     <= gen_b_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.step_b) begin
            rdv_ff <= valid_ff[idx_next];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_a_ff <= PROD_W'(gen_a_ff) * PROD_W'(MUL_A);
         prod_b_ff <= PROD_W'(gen_b_ff) * PROD_W'(MUL_B);
         qest_ff   <= qprod[QPW-1:DATA_W];
      end
      if (cmd.finish) begin
         sample_ff <= y_val;
      end
   end

   // shuffle table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.step_b) begin
         rd_ff  <= mem[idx_next];
         idx_ff <= idx_next;
      end
   end

   assign status.fill_done = (cnt_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = sample_ff;

endmodule

@@ rtl/clsr_ctrl.sv @@
// Sequencer for seeding, warm-up and draw steps.
module clsr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_command,
   output logic                      req_ready,
   input  clsr_pkg::clsr_status_type status,
   output clsr_pkg::clsr_cmd_type    cmd
);
   import clsr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED,
      ST_FIN,
      ST_SMUL,
      ST_SRED
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign accept = ready_ff && req_valid;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_seed = (req_command == CMD_SEED);
               state_in      = (req_command == CMD_SEED) ? ST_SMUL : ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mult = 1'b1;
            state_in = ST_RED;
         end
         ST_RED: begin
            cmd.step_a = 1'b1;
            cmd.step_b = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_SMUL: begin
            cmd.mult = 1'b1;
            state_in = ST_SRED;
         end
         ST_SRED: begin
            cmd.step_a = 1'b1;
            cmd.fill   = 1'b1;
            state_in   = status.fill_done ? ST_MUL : ST_SMUL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

@@ rtl/combined_lcg_shuffled_random.sv @@
// Top level of the combined LCG generator with shuffle table.
// Uniform random source: two multiplicative congruential generators (moduli
// 2147483563 and 2147483399, multipliers 40014 and 40692) combined through a
// TABLE_SIZE-entry shuffle table. A request word with command 0 draws one value;
// command 1 loads both generators with seed_value (0 taken as 1), steps the first
// generator TABLE_SIZE+8 times filling the table from the top entry down, then
// draws. Every request word yields exactly one response word whose sample is the
// numerator of a uniform value over 2147483563. A draw goes from acceptance to the
// response register through the multiply, the modular fold with table read, and the
// subtract with table write-back; the next request is taken in the idle state that
// follows, so draws never overlap. A seed adds one multiply and one fold per warm-up
// step. Each generator has a single multiplier, shared by draw and warm-up steps. The
// response register holds a finished word while the next request is accepted; the
// block stalls only before writing a new result over one not yet taken. After reset
// the table reads as all zeros.
module combined_lcg_shuffled_random #(
   parameter int TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   clsr_req_if.sink        req_port,
   clsr_rsp_if.source      rsp_port
);
   import clsr_pkg::*;

   clsr_cmd_type    cmd;
   clsr_status_type status;
   logic            rsp_valid;
   logic [DATA_W-1:0] rsp_sample;

   // sequencer: request acceptance and step ordering
   clsr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_port.valid),
      .req_command (req_port.command),
      .req_ready   (req_port.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // arithmetic, shuffle table and response register
   clsr_datapath #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .seed_value (req_port.seed_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_port.ready),
      .rsp_sample (rsp_sample)
   );

   assign rsp_port.valid  = rsp_valid;
   assign rsp_port.sample = rsp_sample;

endmodule

@@ rtl/clsr_checker.sv @@
// Port-level assertions for the shuffled LCG generator, bound to the top level.
module clsr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_command,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [clsr_pkg::DATA_W-1:0] rsp_sample
);
   import clsr_pkg::*;

   // a stalled response word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("response word changed while stalled");

   // the wrap keeps every sample above zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample != '0)
      else $error("zero sample");

   // one word at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a draw taken while the response register is empty gets its response word without a stall
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_DRAW) && !rsp_valid
      |-> ##4 rsp_valid)
      else $error("draw latency wrong");

endmodule

bind combined_lcg_shuffled_random clsr_checker u_clsr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .req_command (req_port.command),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .rsp_sample  (rsp_port.sample)
);

@@ tb/combined_lcg_shuffled_random_tb.sv @@
// Self-checking testbench for the combined LCG generator with shuffle table.
module combined_lcg_shuffled_random_tb;

   localparam int DW = clsr_pkg::DATA_W;

   // Generator arithmetic, kept apart from the RTL so the prediction stands alone
   localparam logic [31:0] MODULUS_1  = 32'd2147483563;
   localparam logic [31:0] MODULUS_2  = 32'd2147483399;
   localparam logic [15:0] FACTOR_1   = 16'd40014;
   localparam logic [15:0] FACTOR_2   = 16'd40692;
   localparam logic [31:0] WRAP_SPAN  = MODULUS_1 - 32'd1;
   localparam int          TABLE_LEN  = clsr_pkg::TABLE_SIZE_DEFAULT;
   localparam logic [31:0] BUCKET_W   = 32'd1 + WRAP_SPAN / TABLE_LEN;

   // Run control
   localparam int IDLE_PCT     = 35;
   localparam int DRAIN_CYCLES = 2 * (TABLE_LEN + 8) + 20;  // longer than a seed word
   localparam int HOLD_CYCLES  = 150;
   localparam int RANDOM_WORDS = 420;
   localparam int LIMIT_CYCLES = 300000;

   typedef enum logic {
      OP_DRAW = clsr_pkg::CMD_DRAW,
      OP_SEED = clsr_pkg::CMD_SEED
   } op_type;

   logic clock;
   logic reset;

   clsr_req_if req_bus ();
   clsr_rsp_if rsp_bus ();

   combined_lcg_shuffled_random dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // ---------------------------------------------------------------------
   // Predictor state: both generators, the previous sample and the table,
   // all at their reset values. Reset is applied once, so no re-init.
   // ---------------------------------------------------------------------
   logic [DW-1:0] lcg_a       = DW'(1);
   logic [DW-1:0] lcg_b       = DW'(123456789);
   logic [DW-1:0] last_sample = '0;
   logic [DW-1:0] shuffle [TABLE_LEN];

   logic [DW-1:0] pending_samples [$];

   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   int hold_left      = 0;

   int cycles          = 0;
   int errors          = 0;
   int words_sent      = 0;
   int seeds_sent      = 0;
   int samples_checked = 0;

   initial begin
      foreach (shuffle[i]) shuffle[i] = '0;
   end

   // Exact product modulo m; the seed may exceed the modulus, so no shortcut
   function automatic logic [DW-1:0] lcg_advance(input logic [DW-1:0] x,
                                                  input logic [15:0]   mul,
                                                  input logic [31:0]   m);
      logic [63:0] p;
      p = 64'(x) * 64'(mul);
      return DW'(p % 64'(m));
   endfunction

   // Works out the sample for one request word and moves the predictor on
   function automatic logic [DW-1:0] predict_sample(input op_type op, input logic [DW-1:0] s);
      int            j;
      int            idx;
      logic [DW-1:0] start;
      logic [DW-1:0] picked;
      logic [31:0]   y;
      if (op == OP_SEED) begin
         // zero seed runs as one; warm-up fills the table top entry first
         start = (s == '0) ? DW'(1) : s;
         lcg_a = start;
         lcg_b = start;
         for (j = TABLE_LEN + 7; j >= 0; j--) begin
            lcg_a = lcg_advance(lcg_a, FACTOR_1, MODULUS_1);
            if (j < TABLE_LEN) shuffle[j] = lcg_a;
         end
         last_sample = shuffle[0];
      end
      lcg_a = lcg_advance(lcg_a, FACTOR_1, MODULUS_1);
      lcg_b = lcg_advance(lcg_b, FACTOR_2, MODULUS_2);
      idx = int'(32'(last_sample) / BUCKET_W);
      if (idx >= TABLE_LEN) idx = TABLE_LEN - 1;
      picked = shuffle[idx];
      // strictly greater, else wrap up by the span
      if (picked > lcg_b) begin
         y = 32'(picked) - 32'(lcg_b);
      end else begin
         y = 32'(picked) + WRAP_SPAN - 32'(lcg_b);
      end
      shuffle[idx] = lcg_a;
      last_sample  = y[DW-1:0];
      return last_sample;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, cycle limit
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("combined_lcg_shuffled_random_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Scoreboard. Both sides are sampled at the edge, before this edge's
   // updates land. The response is handled first; a request taken at the
   // same edge can never already have its answer out.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_samples.size() == 0) begin
               $error("sample: expected none, got %0d", rsp_bus.sample);
               errors++;
            end else begin
               logic [DW-1:0] want;
               want = pending_samples.pop_front();
               if (rsp_bus.sample !== want) begin
                  $error("sample: expected %0d, got %0d", want, rsp_bus.sample);
                  errors++;
               end
               samples_checked++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_samples.push_back(predict_sample(op_type'(req_bus.command),
                                                     req_bus.seed_value));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, or a long hold-off counted down here
   // ---------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (receiver_idles) begin
            rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender side. Valid stays up between back-to-back words; idle gaps of random
   // length come before words so they land on every phase of a draw.
   // ---------------------------------------------------------------------
   task automatic send_word(input op_type op, input logic [DW-1:0] s);
      while (sender_idles && ($urandom_range(99) < IDLE_PCT)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= op;
      req_bus.seed_value <= s;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      words_sent++;
      if (op == OP_SEED) seeds_sent++;
   endtask

   // Sender pause: drop valid, let every expected word come back, then settle
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Draws straight out of reset use the all-zero table
   task automatic test_unseeded_draws();
      send_word(OP_DRAW, '0);
      send_word(OP_DRAW, '1);       // seed field ignored on a draw
      send_word(OP_DRAW, DW'(12345));
      wait_drained();
   endtask

   // Seed edge cases, some followed by a draw or two
   task automatic test_seed_extremes();
      send_word(OP_SEED, '0);                       // zero seed runs as one
      send_word(OP_DRAW, '1);
      send_word(OP_SEED, DW'(1));                   // must match the zero seed
      send_word(OP_SEED, '1);                       // largest magnitude
      send_word(OP_DRAW, '0);
      send_word(OP_SEED, DW'(MODULUS_1));           // first generator sticks at zero
      send_word(OP_DRAW, '0);
      send_word(OP_DRAW, '0);
      send_word(OP_SEED, DW'(MODULUS_1 + 32'd1));   // above first modulus
      send_word(OP_SEED, DW'(MODULUS_2));           // second generator sticks at zero
      send_word(OP_DRAW, '0);
      send_word(OP_SEED, DW'(MODULUS_2 - 32'd1));
      send_word(OP_SEED, DW'(123456789));           // seed equal to second reset value
      send_word(OP_DRAW, DW'(31'h5555_5555));
      send_word(OP_DRAW, DW'(31'h2AAA_AAAA));
      send_word(OP_SEED, DW'(31'h4000_0000));
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering words (one a seed), so the
   // response register fills and the block has to stall its input
   task automatic test_backpressure();
      int k;
      hold_left = HOLD_CYCLES;
      for (k = 0; k < 8; k++) begin
         send_word((k == 3) ? OP_SEED : OP_DRAW, DW'($urandom));
      end
      wait_drained();
   endtask

   // Mostly draw runs after a seed; seeds come now and then with mixed values.
   // The middle stretch runs with no idling on either side.
   task automatic test_random_stream(input int count);
      int            i;
      op_type        op;
      logic [DW-1:0] s;
      for (i = 0; i < count; i++) begin
         if (i == count / 3) begin
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
         end
         if (i == count / 3 + 100) begin
            sender_idles   = 1'b1;
            receiver_idles = 1'b1;
         end
         op = ($urandom_range(99) < 12) ? OP_SEED : OP_DRAW;
         case ($urandom_range(9))
            0:       s = '0;
            1:       s = DW'($urandom_range(1000, 1));
            2:       s = DW'(MODULUS_1 + 32'($urandom_range(4)) - 32'd2);
            3:       s = DW'(MODULUS_2 + 32'($urandom_range(4)) - 32'd2);
            4:       s = '1;
            default: s = DW'($urandom);
         endcase
         send_word(op, s);
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= OP_DRAW;
      req_bus.seed_value <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unseeded_draws();
      test_seed_extremes();
      test_backpressure();
      test_random_stream(RANDOM_WORDS);

      $display("Sent %0d request words (%0d seeds incl. zero, modulus and top values),",
               words_sent, seeds_sent);
      $display("checked %0d samples under random stalls and a long receiver hold-off.",
               samples_checked);
      if (errors == 0) begin
         $display("combined_lcg_shuffled_random_tb: done, clean");
      end else begin
         $display("combined_lcg_shuffled_random_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/clsr_pkg.sv
rtl/clsr_channels.sv
rtl/clsr_datapath.sv
rtl/clsr_ctrl.sv
rtl/combined_lcg_shuffled_random.sv
rtl/clsr_checker.sv
tb/combined_lcg_shuffled_random_tb.sv
